FILE: rtl/core/abst_pkg.sv
package abst_pkg;

    typedef enum logic [1:0]
    {
        PH_PROBE  = 2'd0,
        PH_SEARCH = 2'd1,
        PH_STABLE = 2'd2
    } phase_t;

    localparam logic [1:0] FN_REPORT  = 2'd0;
    localparam logic [1:0] FN_RESTART = 2'd1;
    localparam logic [1:0] FN_SAFE    = 2'd2;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATCH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BATCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_FACTOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FRACTION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ADJUST     = 3'd7;

    localparam logic [11:0] GROWTH_FLOOR = 12'd282;

    typedef struct packed
    {
        logic [15:0] min_batch;
        logic [15:0] max_batch;
        logic [15:0] initial_batch;
        logic [15:0] rise_threshold;
        logic [11:0] growth_factor;
        logic [7:0]  shrink_fraction;
        logic [15:0] probe_limit;
        logic        auto_adjust;
    } cfg_t;

    typedef struct packed
    {
        phase_t      phase;
        logic [15:0] suggest_size;
        logic [15:0] best_size;
        logic [31:0] best_time;
        logic [15:0] low_bound;
        logic [15:0] high_bound;
        logic [15:0] prev_size;
        logic [31:0] prev_time;
        logic [15:0] probe_count;
        logic [7:0]  strike_count;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        min_batch:       16'd1,
        max_batch:       16'd1024,
        initial_batch:   16'd1,
        rise_threshold:  16'd6554,
        growth_factor:   12'd512,
        shrink_fraction: 8'd26,
        probe_limit:     16'd10,
        auto_adjust:     1'b1
    };

    localparam state_t STATE_RESET = '{
        phase:        PH_PROBE,
        suggest_size: 16'd1,
        best_size:    16'd0,
        best_time:    32'd0,
        low_bound:    16'd0,
        high_bound:   16'd0,
        prev_size:    16'd0,
        prev_time:    32'd0,
        probe_count:  16'd0,
        strike_count: 8'd0
    };

endpackage

FILE: rtl/core/abst_cfg_regs.sv
module abst_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [abst_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]                   wr_data,
    output abst_pkg::cfg_t                cfg
);

    abst_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= abst_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                abst_pkg::CFG_MIN_BATCH:       cfg_reg.min_batch       <= wr_data;
                abst_pkg::CFG_MAX_BATCH:       cfg_reg.max_batch       <= wr_data;
                abst_pkg::CFG_INITIAL_BATCH:   cfg_reg.initial_batch   <= wr_data;
                abst_pkg::CFG_RISE_THRESHOLD:  cfg_reg.rise_threshold  <= wr_data;
                abst_pkg::CFG_GROWTH_FACTOR:   cfg_reg.growth_factor   <= wr_data[11:0];
                abst_pkg::CFG_SHRINK_FRACTION: cfg_reg.shrink_fraction <= wr_data[7:0];
                abst_pkg::CFG_PROBE_LIMIT:     cfg_reg.probe_limit     <= wr_data;
                abst_pkg::CFG_AUTO_ADJUST:     cfg_reg.auto_adjust     <= wr_data[0];
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/abst_update.sv
module abst_update
#(
    parameter int STRIKE_LIMIT = 3
)
(
    input  abst_pkg::cfg_t   cfg,
    input  abst_pkg::state_t st,
    input  logic [1:0]       func,
    input  logic [15:0]      done_batch,
    input  logic [31:0]      done_time,
    output abst_pkg::state_t nxt
);

    localparam logic [7:0] STRIKE_LIM = 8'(STRIKE_LIMIT);

    logic [31:0] bt_eff;
    logic [31:0] rise_ref;
    logic [16:0] rise_scale;
    logic [48:0] rise_rhs;
    logic        rise_hit;
    logic        best_upd;
    logic [15:0] bs_new;
    logic [31:0] bt_new;

    logic [15:0] pc_inc;
    logic [15:0] p_lo;
    logic [16:0] p_lo_p1;
    logic [16:0] p_hi_raw;
    logic [15:0] p_hi;
    logic [16:0] p_sum;
    logic [11:0] g_eff;
    logic [27:0] grow_prod;
    logic [28:0] grow_sum;
    logic [20:0] grow_ceil;
    logic [20:0] grow_min;
    logic [15:0] grow_next;

    logic        s_bad;
    logic [16:0] b_p1;
    logic [15:0] s_up;
    logic [15:0] s_low;
    logic [15:0] s_high;
    logic [16:0] s_sum;

    logic [7:0]  sc_inc;
    logic [24:0] shr_prod;
    logic [16:0] shr_raw;
    logic [16:0] shr_min;
    logic [15:0] shr_next;

    assign bt_eff = (st.best_time == 32'd0) ? done_time : st.best_time;

    always_comb
    begin
        case (st.phase)
            abst_pkg::PH_PROBE:  rise_ref = st.prev_time;
            abst_pkg::PH_SEARCH: rise_ref = bt_eff;
            default:             rise_ref = st.best_time;
        endcase
    end

    assign rise_scale = {1'b0, cfg.rise_threshold} + 17'h10000;
    assign rise_rhs   = 49'(rise_ref) * 49'(rise_scale);
    assign rise_hit   = {1'b0, done_time, 16'h0000} > rise_rhs;

    assign best_upd = (st.best_time == 32'd0) || (done_time < st.best_time);
    assign bs_new   = best_upd ? done_batch : st.best_size;
    assign bt_new   = best_upd ? done_time : st.best_time;

    // probing
    assign pc_inc   = (st.probe_count == 16'hFFFF) ? st.probe_count : st.probe_count + 16'd1;
    assign p_lo     = (bs_new > cfg.min_batch) ? bs_new : cfg.min_batch;
    assign p_lo_p1  = {1'b0, p_lo} + 17'd1;
    assign p_hi_raw = ({1'b0, done_batch} > p_lo_p1) ? {1'b0, done_batch} : p_lo_p1;
    assign p_hi     = (p_hi_raw > {1'b0, cfg.max_batch}) ? cfg.max_batch : p_hi_raw[15:0];
    assign p_sum    = {1'b0, p_lo} + {1'b0, p_hi};

    assign g_eff     = (cfg.growth_factor < abst_pkg::GROWTH_FLOOR) ?
                       abst_pkg::GROWTH_FLOOR : cfg.growth_factor;
    assign grow_prod = 28'(done_batch) * 28'(g_eff);
    assign grow_sum  = {1'b0, grow_prod} + 29'd255;
    assign grow_ceil = grow_sum[28:8];
    assign grow_min  = (grow_ceil <= 21'(done_batch)) ? 21'(done_batch) + 21'd1 : grow_ceil;
    assign grow_next = (grow_min > 21'(cfg.max_batch)) ? cfg.max_batch : grow_min[15:0];

    // search
    assign s_bad  = (st.low_bound == 16'd0) || (st.high_bound == 16'd0) ||
                    (st.low_bound >= st.high_bound);
    assign b_p1   = {1'b0, done_batch} + 17'd1;
    assign s_up   = (b_p1 > {1'b0, cfg.max_batch}) ? cfg.max_batch : b_p1[15:0];
    assign s_low  = (best_upd || !rise_hit) ? s_up : st.low_bound;
    assign s_high = (best_upd || !rise_hit) ? st.high_bound : done_batch;
    assign s_sum  = {1'b0, s_low} + {1'b0, s_high};

    // stable
    assign sc_inc   = (st.strike_count == 8'hFF) ? st.strike_count : st.strike_count + 8'd1;
    assign shr_prod = 25'(done_batch) * 25'(9'd256 - {1'b0, cfg.shrink_fraction});
    assign shr_raw  = shr_prod[24:8];
    assign shr_min  = (shr_raw < {1'b0, cfg.min_batch}) ? {1'b0, cfg.min_batch} : shr_raw;
    assign shr_next = (shr_min > {1'b0, cfg.max_batch}) ? cfg.max_batch : shr_min[15:0];

    always_comb
    begin
        nxt = st;
        case (func)
            abst_pkg::FN_REPORT:
            begin
                case (st.phase)
                    abst_pkg::PH_PROBE:
                    begin
                        if (done_batch >= cfg.min_batch)
                        begin
                            nxt.probe_count = pc_inc;
                            nxt.best_size   = bs_new;
                            nxt.best_time   = bt_new;
                            if ((st.prev_size != 16'd0) && (st.prev_time != 32'd0) && rise_hit)
                            begin
                                nxt.low_bound  = p_lo;
                                nxt.high_bound = p_hi;
                                if (p_lo >= p_hi)
                                begin
                                    nxt.phase        = abst_pkg::PH_STABLE;
                                    nxt.suggest_size = bs_new;
                                end
                                else
                                begin
                                    nxt.phase        = abst_pkg::PH_SEARCH;
                                    nxt.suggest_size = p_sum[16:1];
                                end
                            end
                            else
                            begin
                                nxt.prev_size = done_batch;
                                nxt.prev_time = done_time;
                                if ((pc_inc >= cfg.probe_limit) || (done_batch >= cfg.max_batch))
                                begin
                                    nxt.phase        = abst_pkg::PH_STABLE;
                                    nxt.suggest_size = bs_new;
                                end
                                else
                                begin
                                    nxt.suggest_size = grow_next;
                                end
                            end
                        end
                    end
                    abst_pkg::PH_SEARCH:
                    begin
                        if (s_bad)
                        begin
                            nxt.phase        = abst_pkg::PH_STABLE;
                            nxt.suggest_size = st.best_size;
                        end
                        else
                        begin
                            nxt.best_size  = bs_new;
                            nxt.best_time  = bt_new;
                            nxt.low_bound  = s_low;
                            nxt.high_bound = s_high;
                            if (s_low >= s_high)
                            begin
                                nxt.phase        = abst_pkg::PH_STABLE;
                                nxt.suggest_size = bs_new;
                            end
                            else
                            begin
                                nxt.suggest_size = s_sum[16:1];
                            end
                        end
                    end
                    default:
                    begin
                        if (cfg.auto_adjust && (st.best_time != 32'd0))
                        begin
                            if (!rise_hit)
                            begin
                                nxt.strike_count = 8'd0;
                            end
                            else if (sc_inc >= STRIKE_LIM)
                            begin
                                nxt.suggest_size = shr_next;
                                nxt.strike_count = 8'd0;
                            end
                            else
                            begin
                                nxt.strike_count = sc_inc;
                            end
                        end
                    end
                endcase
            end
            abst_pkg::FN_RESTART:
            begin
                nxt.phase       = abst_pkg::PH_PROBE;
                nxt.probe_count = 16'd0;
                nxt.low_bound   = 16'd0;
                nxt.high_bound  = 16'd0;
                nxt.prev_size   = 16'd0;
                nxt.prev_time   = 32'd0;
            end
            abst_pkg::FN_SAFE:
            begin
                nxt.suggest_size = cfg.min_batch;
                nxt.strike_count = 8'd0;
            end
            default:
            begin
                nxt = st;
            end
        endcase
    end

endmodule

FILE: rtl/core/adaptive_batch_size_tuner.sv
// A request waits in the input register until it advances; its result then sits in the result register.
// Throughput: one request per cycle unless stalled; the state update is the only loop.
// The input register and the result register each hold one request; the input stalls
// only when both are full and the output is stalled.
// Reset (rst_n low, asynchronous): configuration to defaults, phase probing,
// suggestion 1, all other tuning state zero, both pipeline registers empty.
module adaptive_batch_size_tuner
#(
    parameter int STRIKE_LIMIT = 3
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [abst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic [15:0]                    done_batch,
    input  logic [31:0]                    done_time,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    next_batch,
    output logic [1:0]                     tuning_phase,
    output logic [15:0]                    best_batch,
    output logic [31:0]                    best_time,
    output logic                           stabilized
);

    abst_pkg::cfg_t   cfg;
    abst_pkg::state_t state_reg;
    abst_pkg::state_t state_next;

    logic        in_vld_reg;
    logic [1:0]  func_reg;
    logic [15:0] batch_reg;
    logic [31:0] time_reg;

    logic        out_vld_reg;
    logic [15:0] next_batch_reg;
    logic [1:0]  phase_out_reg;
    logic [15:0] best_batch_reg;
    logic [31:0] best_time_out_reg;
    logic        stable_reg;

    logic        advance;

    assign cfg_ready = 1'b1;

    abst_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    abst_update
    #(
        .STRIKE_LIMIT (STRIKE_LIMIT)
    )
    u_update
    (
        .cfg        (cfg),
        .st         (state_reg),
        .func       (func_reg),
        .done_batch (batch_reg),
        .done_time  (time_reg),
        .nxt        (state_next)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // hold request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            batch_reg <= done_batch;
            time_reg  <= done_time;
        end
    end

    // advance tuning state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= abst_pkg::STATE_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            next_batch_reg    <= state_next.suggest_size;
            phase_out_reg     <= state_next.phase;
            best_batch_reg    <= state_next.best_size;
            best_time_out_reg <= state_next.best_time;
            stable_reg        <= (state_next.phase == abst_pkg::PH_STABLE);
        end
    end

    assign out_valid    = out_vld_reg;
    assign next_batch   = next_batch_reg;
    assign tuning_phase = phase_out_reg;
    assign best_batch   = best_batch_reg;
    assign best_time    = best_time_out_reg;
    assign stabilized   = stable_reg;

endmodule

FILE: bench/testbench.sv
module testbench;

    localparam int STRIKES_TO_SHRINK = 3;
    localparam logic [11:0] SLOWEST_GROWTH = 12'd282;
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int REQUEST_TARGET = 1100;
    localparam int REQUESTS_PER_SETTING = 180;

    typedef struct packed
    {
        logic [15:0] next_batch;
        logic [1:0]  phase_code;
        logic [15:0] best_batch;
        logic [31:0] best_time;
        logic        stabilized;
    } suggestion_t;

    class tuner_scoreboard;
        abst_pkg::cfg_t   settings;
        abst_pkg::state_t tuning;
        suggestion_t expected_suggestions[$];
        int results_checked;
        int mismatches;
        int unexpected;
        int reported;
        int reports;
        int restarts;
        int safe_resets;
        int unused_codes;
        int register_writes;
        int search_entries;
        int stable_entries;
        int shrinks;

        function new();
            settings.min_batch       = 16'd1;
            settings.max_batch       = 16'd1024;
            settings.initial_batch   = 16'd1;
            settings.rise_threshold  = 16'd6554;
            settings.growth_factor   = 12'd512;
            settings.shrink_fraction = 8'd26;
            settings.probe_limit     = 16'd10;
            settings.auto_adjust     = 1'b1;
            tuning                   = '0;
            tuning.phase             = abst_pkg::PH_PROBE;
            tuning.suggest_size      = 16'd1;
        endfunction

        function void set_register(logic [abst_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            register_writes++;
            case (idx)
                abst_pkg::CFG_MIN_BATCH:       settings.min_batch = data;
                abst_pkg::CFG_MAX_BATCH:       settings.max_batch = data;
                abst_pkg::CFG_INITIAL_BATCH:   settings.initial_batch = data;
                abst_pkg::CFG_RISE_THRESHOLD:  settings.rise_threshold = data;
                abst_pkg::CFG_GROWTH_FACTOR:   settings.growth_factor = data[11:0];
                abst_pkg::CFG_SHRINK_FRACTION: settings.shrink_fraction = data[7:0];
                abst_pkg::CFG_PROBE_LIMIT:     settings.probe_limit = data;
                abst_pkg::CFG_AUTO_ADJUST:     settings.auto_adjust = data[0];
                default:                       ;
            endcase
        endfunction

        function bit exceeds_rise(logic [31:0] t, logic [31:0] ref_time);
            logic [63:0] scaled_t;
            logic [63:0] allowed;
            scaled_t = {16'd0, t, 16'd0};
            allowed = 64'(ref_time) * (64'd65536 + 64'(settings.rise_threshold));
            return scaled_t > allowed;
        endfunction

        function void settle();
            stable_entries++;
            tuning.phase = abst_pkg::PH_STABLE;
            tuning.suggest_size = tuning.best_size;
        endfunction

        function void tune_probe(logic [15:0] b, logic [31:0] t);
            logic [16:0] lo;
            logic [16:0] hi;
            logic [11:0] g;
            logic [31:0] grown;
            if (b < settings.min_batch)
                return;
            if (tuning.probe_count != 16'hFFFF)
                tuning.probe_count++;
            if (tuning.best_time == 32'd0 || t < tuning.best_time)
            begin
                tuning.best_time = t;
                tuning.best_size = b;
            end
            if (tuning.prev_size != 16'd0 && tuning.prev_time != 32'd0
                && exceeds_rise(t, tuning.prev_time))
            begin
                lo = (tuning.best_size > settings.min_batch) ? {1'b0, tuning.best_size}
                                                             : {1'b0, settings.min_batch};
                hi = ({1'b0, b} > lo + 17'd1) ? {1'b0, b} : lo + 17'd1;
                if (hi > {1'b0, settings.max_batch})
                    hi = {1'b0, settings.max_batch};
                tuning.low_bound = lo[15:0];
                tuning.high_bound = hi[15:0];
                if (lo >= hi)
                    settle();
                else
                begin
                    search_entries++;
                    tuning.phase = abst_pkg::PH_SEARCH;
                    tuning.suggest_size = 16'((lo + hi) >> 1);
                end
                return;
            end
            tuning.prev_size = b;
            tuning.prev_time = t;
            if (tuning.probe_count >= settings.probe_limit || b >= settings.max_batch)
            begin
                settle();
                return;
            end
            g = (settings.growth_factor < SLOWEST_GROWTH) ? SLOWEST_GROWTH
                                                          : settings.growth_factor;
            grown = (32'(b) * 32'(g) + 32'd255) >> 8;
            if (grown <= 32'(b))
                grown = 32'(b) + 32'd1;
            if (grown > 32'(settings.max_batch))
                grown = 32'(settings.max_batch);
            tuning.suggest_size = grown[15:0];
        endfunction

        function void tune_search(logic [15:0] b, logic [31:0] t);
            logic [31:0] bt;
            logic [16:0] up;
            if (tuning.low_bound == 16'd0 || tuning.high_bound == 16'd0
                || tuning.low_bound >= tuning.high_bound)
            begin
                settle();
                return;
            end
            bt = tuning.best_time;
            if (bt == 32'd0)
            begin
                bt = t;
                tuning.best_time = t;
                tuning.best_size = b;
            end
            up = {1'b0, b} + 17'd1;
            if (up > {1'b0, settings.max_batch})
                up = {1'b0, settings.max_batch};
            if (t < bt)
            begin
                tuning.best_time = t;
                tuning.best_size = b;
                tuning.low_bound = up[15:0];
            end
            else if (exceeds_rise(t, bt))
                tuning.high_bound = b;
            else
                tuning.low_bound = up[15:0];
            if (tuning.low_bound >= tuning.high_bound)
            begin
                settle();
                return;
            end
            tuning.suggest_size = 16'(({1'b0, tuning.low_bound} + {1'b0, tuning.high_bound}) >> 1);
        endfunction

        function void tune_stable(logic [15:0] b, logic [31:0] t);
            logic [8:0]  keep;
            logic [23:0] trimmed;
            logic [15:0] n;
            if (!settings.auto_adjust || tuning.best_time == 32'd0)
                return;
            if (!exceeds_rise(t, tuning.best_time))
            begin
                tuning.strike_count = 8'd0;
                return;
            end
            if (tuning.strike_count != 8'hFF)
                tuning.strike_count++;
            if (tuning.strike_count >= STRIKES_TO_SHRINK)
            begin
                keep = 9'd256 - 9'(settings.shrink_fraction);
                trimmed = 24'(b) * 24'(keep);
                n = trimmed[23:8];
                if (n < settings.min_batch)
                    n = settings.min_batch;
                if (n > settings.max_batch)
                    n = settings.max_batch;
                tuning.suggest_size = n;
                tuning.strike_count = 8'd0;
                shrinks++;
            end
        endfunction

        function void note_request(logic [1:0] f, logic [15:0] b, logic [31:0] t);
            case (f)
                abst_pkg::FN_REPORT:
                begin
                    reports++;
                    case (tuning.phase)
                        abst_pkg::PH_PROBE:  tune_probe(b, t);
                        abst_pkg::PH_SEARCH: tune_search(b, t);
                        default:             tune_stable(b, t);
                    endcase
                end
                abst_pkg::FN_RESTART:
                begin
                    restarts++;
                    tuning.phase = abst_pkg::PH_PROBE;
                    tuning.probe_count = 16'd0;
                    tuning.low_bound = 16'd0;
                    tuning.high_bound = 16'd0;
                    tuning.prev_size = 16'd0;
                    tuning.prev_time = 32'd0;
                end
                abst_pkg::FN_SAFE:
                begin
                    safe_resets++;
                    tuning.suggest_size = settings.min_batch;
                    tuning.strike_count = 8'd0;
                end
                default: unused_codes++;
            endcase
            expected_suggestions.push_back(suggestion_t'({tuning.suggest_size, tuning.phase,
                tuning.best_size, tuning.best_time, tuning.phase == abst_pkg::PH_STABLE}));
        endfunction

        function void check_result(suggestion_t got);
            suggestion_t want;
            if (expected_suggestions.size() == 0)
            begin
                unexpected++;
                if (reported < 10)
                    $display("unexpected result: next %0d phase %0d best %0d/%0d stable %0b",
                             got.next_batch, got.phase_code, got.best_batch, got.best_time,
                             got.stabilized);
                reported++;
                return;
            end
            want = expected_suggestions.pop_front();
            results_checked++;
            if (got.next_batch !== want.next_batch || got.phase_code !== want.phase_code
                || got.best_batch !== want.best_batch || got.best_time !== want.best_time
                || got.stabilized !== want.stabilized)
            begin
                mismatches++;
                if (reported < 10)
                    $display({"result %0d: expected next %0d phase %0d best %0d/%0d ",
                              "stable %0b, got next %0d phase %0d best %0d/%0d stable %0b"},
                             results_checked, want.next_batch, want.phase_code,
                             want.best_batch, want.best_time, want.stabilized,
                             got.next_batch, got.phase_code, got.best_batch,
                             got.best_time, got.stabilized);
                reported++;
            end
        endfunction

        function int pending();
            return expected_suggestions.size();
        endfunction

        function int total_requests();
            return reports + restarts + safe_resets + unused_codes;
        endfunction

        function int failures();
            return mismatches + unexpected + expected_suggestions.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [abst_pkg::CFG_IDX_W-1:0] cfg_index = abst_pkg::CFG_MIN_BATCH;
    logic [15:0]                    cfg_data = 16'd0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     func = abst_pkg::FN_REPORT;
    logic [15:0]                    done_batch = 16'd0;
    logic [31:0]                    done_time = 32'd0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [15:0]                    next_batch;
    logic [1:0]                     tuning_phase;
    logic [15:0]                    best_batch;
    logic [31:0]                    best_time;
    logic                           stabilized;

    int send_idle_pct = 22;
    int stall_pct = 46;
    tuner_scoreboard sb;

    adaptive_batch_size_tuner #(.STRIKE_LIMIT(STRIKES_TO_SHRINK)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .done_batch(done_batch),
        .done_time(done_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .next_batch(next_batch),
        .tuning_phase(tuning_phase),
        .best_batch(best_batch),
        .best_time(best_time),
        .stabilized(stabilized)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(suggestion_t'({next_batch, tuning_phase, best_batch, best_time,
                                           stabilized}));
    end

    task automatic send_request(logic [1:0] f, logic [15:0] b, logic [31:0] t);
        in_valid <= 1'b1;
        func <= f;
        done_batch <= b;
        done_time <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(f, b, t);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic drain_suggestions();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [abst_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic program_settings(int kind);
        logic [15:0] lowest;
        logic [15:0] highest;
        logic [15:0] first;
        logic [15:0] rise;
        logic [15:0] growth;
        logic [15:0] shrink;
        logic [15:0] limit;
        logic [15:0] adjust;
        case (kind)
            1:
            begin
                lowest = 16'd1;
                highest = 16'hFFFF;
                first = 16'hFFFF;
                rise = 16'hFFFF;
                growth = 16'h0FFF;
                shrink = 16'h00FF;
                limit = 16'hFFFF;
                adjust = 16'd1;
            end
            2:
            begin
                lowest = 16'd1;
                highest = 16'd1;
                first = 16'd1;
                rise = 16'd0;
                growth = 16'd256;
                shrink = 16'd0;
                limit = 16'd1;
                adjust = 16'd0;
            end
            3:
            begin
                lowest = 16'($urandom_range(0, 300));
                highest = 16'($urandom_range(1, 512));
                first = 16'($urandom);
                rise = 16'($urandom);
                growth = 16'($urandom);
                shrink = 16'($urandom);
                limit = 16'($urandom_range(0, 3));
                adjust = 16'($urandom);
            end
            default:
            begin
                lowest = 16'($urandom_range(1, 8));
                highest = 16'($urandom_range(16, 4096));
                first = 16'($urandom_range(1, 64));
                rise = 16'($urandom_range(0, 40000));
                growth = 16'($urandom_range(200, 1100));
                shrink = 16'($urandom_range(0, 255));
                limit = 16'($urandom_range(1, 24));
                adjust = ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0;
            end
        endcase
        write_register(abst_pkg::CFG_MIN_BATCH, lowest);
        write_register(abst_pkg::CFG_MAX_BATCH, highest);
        write_register(abst_pkg::CFG_INITIAL_BATCH, first);
        write_register(abst_pkg::CFG_RISE_THRESHOLD, rise);
        write_register(abst_pkg::CFG_GROWTH_FACTOR, growth);
        write_register(abst_pkg::CFG_SHRINK_FRACTION, shrink);
        write_register(abst_pkg::CFG_PROBE_LIMIT, limit);
        write_register(abst_pkg::CFG_AUTO_ADJUST, adjust);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] batch_time(logic [15:0] b, logic [31:0] base,
                                               logic [15:0] slope, logic [16:0] knee,
                                               logic [7:0] steep, bit spiking);
        logic [63:0] cost;
        cost = 64'(base) + 64'(slope) * 64'(b) + 64'($urandom_range(0, slope));
        if ({1'b0, b} > knee)
            cost = cost + 64'({1'b0, b} - knee) * 64'(slope) * 64'(steep);
        if (spiking)
            cost = cost * 3;
        return (cost > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cost[31:0];
    endfunction

    task automatic run_workload();
        logic [31:0] base;
        logic [15:0] slope;
        logic [16:0] knee;
        logic [7:0]  steep;
        logic [15:0] b;
        int          spike_left;
        int          roll;
        spike_left = 0;
        if ($urandom_range(0, 99) < 70)
            send_request(abst_pkg::FN_RESTART, 16'($urandom), $urandom);
        base = $urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(10000, 400000);
        slope = 16'($urandom_range(1, 60));
        knee = 17'($urandom_range(1, 70000));
        steep = 8'($urandom_range(1, 40));
        repeat ($urandom_range(4, 40))
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                send_request(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
            else if (roll < 13)
                send_request(abst_pkg::FN_SAFE, 16'($urandom), $urandom);
            else
            begin
                if (spike_left == 0 && $urandom_range(0, 99) < 8)
                    spike_left = $urandom_range(2, 4);
                b = sb.tuning.suggest_size;
                if ($urandom_range(0, 99) < 15)
                    b = b + 16'($urandom_range(0, 6)) - 16'd3;
                send_request(abst_pkg::FN_REPORT, b, batch_time(b, base, slope, knee, steep,
                                                                spike_left != 0));
                if (spike_left != 0)
                    spike_left--;
            end
        end
    endtask

    initial
    begin
        int setting_kinds[8];
        int round;
        int next_switch;
        int n;
        setting_kinds = '{0, 1, 0, 3, 2, 0, 3, 0};
        round = 0;
        next_switch = REQUESTS_PER_SETTING;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default settings: probe, search, settle, shrink, safe reset, restart
        send_request(abst_pkg::FN_REPORT, 16'd0, 32'd5);
        send_request(FN_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(abst_pkg::FN_SAFE, 16'd0, 32'd0);
        send_request(abst_pkg::FN_REPORT, 16'd1, 32'd1000);
        send_request(abst_pkg::FN_REPORT, 16'd2, 32'd1050);
        send_request(abst_pkg::FN_REPORT, 16'd4, 32'd1100);
        send_request(abst_pkg::FN_REPORT, 16'd8, 32'd1400);
        send_request(abst_pkg::FN_REPORT, 16'd4, 32'd900);
        send_request(abst_pkg::FN_REPORT, 16'd6, 32'd2000);
        send_request(abst_pkg::FN_REPORT, 16'd5, 32'd950);
        repeat (3)
            send_request(abst_pkg::FN_REPORT, 16'd4, 32'hFFFF_FFFF);
        send_request(abst_pkg::FN_REPORT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(abst_pkg::FN_REPORT, 16'd3, 32'd0);
        repeat (3)
            send_request(abst_pkg::FN_REPORT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(abst_pkg::FN_RESTART, 16'd0, 32'd0);
        send_request(abst_pkg::FN_REPORT, 16'hFFFF, 32'd0);
        send_request(abst_pkg::FN_REPORT, 16'd10, 32'd7);
        send_request(abst_pkg::FN_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(abst_pkg::FN_REPORT, 16'd2, 32'd0);
        send_request(abst_pkg::FN_REPORT, 16'd4, 32'd100);

        drain_suggestions();
        program_settings(0);

        while (sb.total_requests() < REQUEST_TARGET)
        begin
            n = sb.total_requests();
            if (n < 380)
            begin
                send_idle_pct = 22;
                stall_pct = 46;
            end
            else if (n < 750)
            begin
                send_idle_pct = 46;
                stall_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            if (n >= next_switch)
            begin
                drain_suggestions();
                program_settings(setting_kinds[round % 8]);
                round++;
                next_switch += REQUESTS_PER_SETTING;
            end
            else if ($urandom_range(0, 99) < 4)
                drain_suggestions();
            run_workload();
        end

        drain_suggestions();
        repeat (4) @(posedge clk);
        $display({"Covered %0d requests: %0d reports, %0d restarts, %0d safe resets, ",
                  "%0d unused codes; %0d register writes"},
                 sb.total_requests(), sb.reports, sb.restarts, sb.safe_resets,
                 sb.unused_codes, sb.register_writes);
        $display({"Search entered %0d times, stable %0d times, %0d forced shrinks; ",
                  "%0d results checked"},
                 sb.search_entries, sb.stable_entries, sb.shrinks, sb.results_checked);
        if (sb.failures() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/abst_pkg.sv
rtl/core/abst_cfg_regs.sv
rtl/core/abst_update.sv
rtl/core/adaptive_batch_size_tuner.sv
bench/testbench.sv
